[hw/rtl/hts_pkg.sv]
// ============================================================================
// hts_pkg: shared types and constants of the HTML tag stripper
// Holds the entity table, the tracking state and the result bundle types.
// ============================================================================
package hts_pkg;

    localparam int unsigned MaxResults = 6;
    localparam int unsigned HoldDepth  = 4;
    localparam int unsigned NumEnt     = 6;

    localparam logic [7:0] ChAmp   = 8'h26;
    localparam logic [7:0] ChLt    = 8'h3C;
    localparam logic [7:0] ChGt    = 8'h3E;
    localparam logic [7:0] ChSpace = 8'h20;
    localparam logic [7:0] ChTab   = 8'h09;
    localparam logic [7:0] ChCr    = 8'h0D;

    typedef logic [4:0][7:0] ent_text_t;

    // Tracking state carried from one byte to the next.
    typedef struct packed {
        logic                           inside_tag;
        logic                           space_owed;
        logic                           any_written;
        logic                           amp_held;
        logic [2:0]                     held_count;
        logic [HoldDepth-1:0][7:0]      held_bytes;
    } hts_state_t;

    // The bytes written for one input transaction, in order from entry 0.
    typedef struct packed {
        logic [MaxResults-1:0][7:0] bytes;
        logic [2:0]                 count;
    } hts_res_t;

    // Entity names without the leading ampersand, entry 0 is the first character.
    function automatic ent_text_t ent_text(input logic [2:0] idx);
        ent_text_t t;
        unique case (idx)
            3'd0:    t = {8'h00, ";", "p", "m", "a"};
            3'd1:    t = {8'h00, 8'h00, ";", "t", "l"};
            3'd2:    t = {8'h00, 8'h00, ";", "t", "g"};
            3'd3:    t = {";", "t", "o", "u", "q"};
            3'd4:    t = {8'h00, ";", "9", "3", "#"};
            3'd5:    t = {";", "p", "s", "b", "n"};
            default: t = '0;
        endcase
        return t;
    endfunction

    function automatic logic [2:0] ent_len(input logic [2:0] idx);
        logic [2:0] l;
        unique case (idx)
            3'd0, 3'd4: l = 3'd4;
            3'd1, 3'd2: l = 3'd3;
            3'd3, 3'd5: l = 3'd5;
            default:    l = 3'd0;
        endcase
        return l;
    endfunction

    function automatic logic [7:0] ent_plain(input logic [2:0] idx);
        logic [7:0] p;
        unique case (idx)
            3'd0:    p = ChAmp;
            3'd1:    p = ChLt;
            3'd2:    p = ChGt;
            3'd3:    p = 8'h22;
            3'd4:    p = 8'h27;
            3'd5:    p = ChSpace;
            default: p = 8'h00;
        endcase
        return p;
    endfunction

    // Appends one byte to the result bundle; the bundle never overflows in use.
    function automatic hts_res_t res_push(input hts_res_t r, input logic [7:0] b);
        hts_res_t o;
        o = r;
        if (r.count < 3'(MaxResults)) begin
            o.bytes[r.count] = b;
            o.count          = r.count + 3'd1;
        end
        return o;
    endfunction

    function automatic logic is_ws(input logic [7:0] c);
        return (c == ChSpace) || ((c >= ChTab) && (c <= ChCr));
    endfunction

endpackage

[hw/rtl/hts_decode.sv]
// ============================================================================
// hts_decode: per-byte decision logic
// From the tracking state and one byte, forms every byte to be written and
// the state that follows.
// ============================================================================
module hts_decode
    import hts_pkg::*;
(
    input  hts_state_t  state_in,
    input  logic [7:0]  in_byte,
    input  logic        doc_last,
    output hts_state_t  state_out,
    output hts_res_t    res_out
);

    logic [2:0]        held_n;
    logic [NumEnt-1:0] ent_match;
    logic              hit;
    logic [2:0]        hit_idx;

    assign held_n = (state_in.held_count > 3'd3) ? 3'd4 : state_in.held_count;

    // Compare the held bytes plus the current byte against every entity name.
    always_comb begin
        ent_text_t t;
        logic      pre_ok;
        for (int i = 0; i < NumEnt; i++) begin
            t      = ent_text(3'(i));
            pre_ok = 1'b1;
            for (int k = 0; k < HoldDepth; k++) begin
                if ((3'(k) < held_n) && (state_in.held_bytes[k] != t[k])) begin
                    pre_ok = 1'b0;
                end
            end
            ent_match[i] = (ent_len(3'(i)) > held_n) && pre_ok && (t[held_n] == in_byte);
        end
    end

    always_comb begin
        hit     = 1'b0;
        hit_idx = '0;
        for (int i = NumEnt - 1; i >= 0; i--) begin
            if (ent_match[i]) begin
                hit     = 1'b1;
                hit_idx = 3'(i);
            end
        end
    end

    always_comb begin
        hts_state_t s;
        hts_res_t   r;
        logic       do_plain;
        s        = state_in;
        r        = '0;
        do_plain = 1'b0;

        if (s.amp_held) begin
            if (hit && (ent_len(hit_idx) == held_n + 3'd1)) begin
                r             = res_push(r, ent_plain(hit_idx));
                s.any_written = 1'b1;
                s.amp_held    = 1'b0;
                s.held_count  = '0;
            end else if (hit && (held_n < 3'(HoldDepth))) begin
                s.held_bytes[held_n[1:0]] = in_byte;
                s.held_count              = held_n + 3'd1;
            end else begin
                // Not an entity after all: the ampersand and held bytes go out as they are.
                r = res_push(r, ChAmp);
                for (int k = 0; k < HoldDepth; k++) begin
                    if (3'(k) < held_n) begin
                        r = res_push(r, s.held_bytes[k]);
                    end
                end
                s.any_written = 1'b1;
                s.amp_held    = 1'b0;
                s.held_count  = '0;
                do_plain      = 1'b1;
            end
        end else begin
            do_plain = 1'b1;
        end

        if (do_plain) begin
            if (s.inside_tag) begin
                if (in_byte == ChGt) begin
                    s.inside_tag = 1'b0;
                    s.space_owed = 1'b1;
                end
            end else if (in_byte == ChLt) begin
                s.inside_tag = 1'b1;
            end else if (is_ws(in_byte)) begin
                s.space_owed = 1'b1;
            end else begin
                if (s.space_owed && s.any_written) begin
                    r = res_push(r, ChSpace);
                end
                s.space_owed = 1'b0;
                if (in_byte == ChAmp) begin
                    s.amp_held   = 1'b1;
                    s.held_count = '0;
                end else begin
                    r             = res_push(r, in_byte);
                    s.any_written = 1'b1;
                end
            end
        end

        if (doc_last) begin
            if (s.amp_held) begin
                r = res_push(r, ChAmp);
                for (int k = 0; k < HoldDepth; k++) begin
                    if (3'(k) < s.held_count) begin
                        r = res_push(r, s.held_bytes[k]);
                    end
                end
            end
            s.inside_tag  = 1'b0;
            s.space_owed  = 1'b0;
            s.any_written = 1'b0;
            s.amp_held    = 1'b0;
            s.held_count  = '0;
        end

        state_out = s;
        res_out   = r;
    end

endmodule

[hw/rtl/html_tag_strip_entity_decode.sv]
// ============================================================================
// html_tag_strip_entity_decode: HTML to plain text stream converter
// Drops markup, collapses whitespace and decodes a small set of entities.
// ============================================================================
// Path: an accepted byte waits in the input register, is decoded, and its
// results are registered in the result buffer that drives the master side.
// Throughput: one input transaction per cycle while each byte gives at most one
// result and the master side takes every result; a byte that gives several
// results holds the input while the buffer drains them, one per cycle.
// Reset: aresetn is synchronous and active low; it clears the tracking state,
// the input register and the result buffer.
module html_tag_strip_entity_decode
    import hts_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    // Input channel
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,   // [7:0] in_byte
    input  logic       s_tlast,   // doc_last
    // Result channel
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata,   // [7:0] out_byte
    output logic       m_tlast    // run_last
);

    // Input register: holds one byte until the result buffer can take its results.
    logic       in_valid_reg;
    logic [7:0] in_byte_reg;
    logic       in_last_reg;

    // Tracking state between bytes.
    hts_state_t state_reg;
    hts_state_t state_next;

    // Result buffer: all bytes written for one input transaction, and a read
    // pointer that walks through them one result transaction at a time.
    hts_res_t   res_reg;
    hts_res_t   res_next;
    logic [2:0] idx_reg;

    logic pop;
    logic final_pop;
    logic buf_free;
    logic load;

    hts_decode u_decode (
        .state_in  (state_reg),
        .in_byte   (in_byte_reg),
        .doc_last  (in_last_reg),
        .state_out (state_next),
        .res_out   (res_next)
    );

    // The buffer holds results while the pointer is below the count.
    assign m_tvalid  = (idx_reg < res_reg.count);
    assign m_tlast   = m_tvalid && (idx_reg == res_reg.count - 3'd1);
    assign m_tdata   = m_tvalid ? res_reg.bytes[idx_reg] : 8'h00;

    assign pop       = m_tvalid && m_tready;
    assign final_pop = pop && m_tlast;
    // The buffer may be refilled in the same cycle its last result leaves.
    assign buf_free  = !m_tvalid || final_pop;
    assign load      = in_valid_reg && buf_free;
    assign s_tready  = !in_valid_reg || load;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
        if (s_tvalid && s_tready) begin
            in_byte_reg <= s_tdata;
            in_last_reg <= s_tlast;
        end
    end

    // Control fields of the state are reset; held bytes are only read once written.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg.inside_tag  <= 1'b0;
            state_reg.space_owed  <= 1'b0;
            state_reg.any_written <= 1'b0;
            state_reg.amp_held    <= 1'b0;
            state_reg.held_count  <= '0;
        end else if (load) begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            res_reg.count <= '0;
            idx_reg       <= '0;
        end else if (load) begin
            res_reg <= res_next;
            idx_reg <= '0;
        end else if (pop) begin
            idx_reg <= idx_reg + 3'd1;
        end
    end

endmodule

[hw/rtl/hts_checker.sv]
// ============================================================================
// hts_checker: port-level checks of the HTML tag stripper
// Watches both channels and flags behaviour the design must never show.
// ============================================================================
module hts_checker
    import hts_pkg::*;
(
    input logic       aclk,
    input logic       aresetn,
    input logic       s_tready,
    input logic       m_tvalid,
    input logic       m_tready,
    input logic [7:0] m_tdata,
    input logic       m_tlast
);

    // A stalled result transaction keeps its payload.
    a_m_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
        else $error("result transaction changed while stalled");

    // Reset leaves nothing pending on the result channel.
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid directly after reset");

    // Whitespace other than a plain space is always collapsed.
    a_no_ctrl_ws: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> !((m_tdata >= ChTab) && (m_tdata <= ChCr)))
        else $error("control whitespace reached the output");

    // The input stalls only while results are waiting to be taken.
    a_stall_cause: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_tready |-> m_tvalid)
        else $error("input stalled with an empty result buffer");

    // The results of one input transaction follow each other without gaps.
    a_run_contig: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tready && !m_tlast |=> m_tvalid)
        else $error("gap inside a run of results");

endmodule

bind html_tag_strip_entity_decode hts_checker u_hts_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
);
